// ===== sv/ikht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ikht_pkg
// Types and constants shared by the integer key hash table modules.
// ----------------------------------------------------------------------------

package ikht_pkg;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_PUT   = 3'd1;
    localparam logic [2:0] OP_DEL   = 3'd2;
    localparam logic [2:0] OP_GET   = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    // key bits that feed the hash (top byte dropped)
    localparam int          KEY_HASH_W = 24;
    localparam logic [31:0] HASH_MULT  = 32'd2654435761;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] key;
        logic [63:0]        value;
    } req_t;

    typedef struct packed {
        logic        found;
        logic        ok;
        logic        bucket_full;
        logic [63:0] read_value;
    } res_t;

    typedef struct packed {
        logic take;
        logic sweeping;
    } tbl_stat_t;

endpackage

`default_nettype wire

// ===== sv/ikht_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ikht_req_if
// Request channel: one operation beat with key and value.
// ----------------------------------------------------------------------------

interface ikht_req_if;

    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic signed [31:0] key;
    logic [63:0]        value;

    modport source (output valid, output operation, output key, output value, input ready);
    modport sink   (input valid, input operation, input key, input value, output ready);

endinterface

`default_nettype wire

// ===== sv/ikht_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ikht_res_if
// Response channel: status flags and read data for one operation.
// ----------------------------------------------------------------------------

interface ikht_res_if;

    logic        valid;
    logic        ready;
    logic        found;
    logic        ok;
    logic        bucket_full;
    logic [63:0] read_value;

    modport source (output valid, output found, output ok, output bucket_full,
                    output read_value, input ready);
    modport sink   (input valid, input found, input ok, input bucket_full,
                    input read_value, output ready);

endinterface

`default_nettype wire

// ===== sv/ikht_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ikht_hash
// Pipelined bucket index: (key low 24 bits * multiplier) mod bucket count,
// done as two reciprocal reductions with one multiplier per stage.
// ----------------------------------------------------------------------------

module ikht_hash
    import ikht_pkg::*;
#(
    parameter  int BUCKETS = 256,
    localparam int BW      = $clog2(BUCKETS)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          in_take,
    input  wire req_t          in_req,
    output logic               out_valid,
    output req_t               out_req,
    output logic [BW-1:0]      out_bucket
);

    localparam int KW  = KEY_HASH_W;
    localparam int BV  = BW + 1;
    localparam int SH1 = KW + BW;
    localparam int R1W = KW + 1;
    localparam int YW  = 2 * BW;
    localparam int SH2 = YW + BW;
    localparam int R2W = YW + 1;
    localparam int NS  = 7;

    localparam logic [63:0] R1 = ((64'd1 << SH1) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [63:0] R2 = ((64'd1 << SH2) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [63:0] MR = 64'(HASH_MULT) % 64'(BUCKETS);

    logic [NS:1]            v_reg;
    req_t                   req_reg [1:NS];
    logic [KW-1:0]          n_reg   [1:3];
    logic [KW+R1W-1:0]      p1_reg;
    logic [KW-1:0]          t1_reg;
    logic [YW-1:0]          y_reg   [4:6];
    logic [YW+R2W-1:0]      p2_reg;
    logic [YW-1:0]          t2_reg;
    logic [BW-1:0]          bkt_reg;

    logic [KW-1:0]          n_next;
    logic [KW+R1W-1:0]      p1_next;
    logic [KW-1:0]          q1;
    logic [KW-1:0]          t1_next;
    logic [BW-1:0]          x1;
    logic [YW-1:0]          y_next;
    logic [YW+R2W-1:0]      p2_next;
    logic [YW-1:0]          q2;
    logic [YW-1:0]          t2_next;
    logic [BW-1:0]          bkt_next;

    always_comb
    begin
        n_next   = in_req.key[KW-1:0];
        p1_next  = (KW+R1W)'(n_reg[1]) * (KW+R1W)'(R1);
        q1       = KW'(p1_reg >> SH1);
        t1_next  = KW'((KW+BV)'(q1) * (KW+BV)'(BUCKETS));
        x1       = BW'(n_reg[3] - t1_reg);
        y_next   = YW'(x1) * YW'(MR);
        p2_next  = (YW+R2W)'(y_reg[4]) * (YW+R2W)'(R2);
        q2       = YW'(p2_reg >> SH2);
        t2_next  = YW'((YW+BV)'(q2) * (YW+BV)'(BUCKETS));
        bkt_next = BW'(y_reg[6] - t2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NS-1:1], in_take};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            req_reg[1] <= in_req;
            for (int i = 2; i <= NS; i++)
            begin
                req_reg[i] <= req_reg[i-1];
            end
            n_reg[1] <= n_next;
            n_reg[2] <= n_reg[1];
            n_reg[3] <= n_reg[2];
            p1_reg   <= p1_next;
            t1_reg   <= t1_next;
            y_reg[4] <= y_next;
            y_reg[5] <= y_reg[4];
            y_reg[6] <= y_reg[5];
            p2_reg   <= p2_next;
            t2_reg   <= t2_next;
            bkt_reg  <= bkt_next;
        end
    end

    assign out_valid  = v_reg[NS];
    assign out_req    = req_reg[NS];
    assign out_bucket = bkt_reg;

endmodule

`default_nettype wire

// ===== sv/ikht_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ikht_table
// Bucket row memories, row read register with write forwarding, slot match
// and update logic, valid-bit sweep and the response register.
// ----------------------------------------------------------------------------

module ikht_table
    import ikht_pkg::*;
#(
    parameter  int BUCKETS          = 256,
    parameter  int SLOTS_PER_BUCKET = 4,
    localparam int BW               = $clog2(BUCKETS)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire req_t          in_req,
    input  wire logic [BW-1:0] in_bucket,
    input  wire logic          out_ready,
    output tbl_stat_t          stat,
    output logic               out_valid,
    output res_t               out_res
);

    localparam int NSL = SLOTS_PER_BUCKET;
    localparam logic [BW-1:0] LAST_ROW = BW'(BUCKETS - 1);

    logic [NSL-1:0]            vmem [BUCKETS];
    logic [NSL-1:0][31:0]      kmem [BUCKETS];
    logic [NSL-1:0][63:0]      dmem [BUCKETS];

    logic                      rd_valid_reg;
    req_t                      rd_req_reg;
    logic [BW-1:0]             rd_bucket_reg;
    logic [NSL-1:0]            row_v_reg;
    logic [NSL-1:0][31:0]      row_k_reg;
    logic [NSL-1:0][63:0]      row_d_reg;

    logic                      res_valid_reg;
    res_t                      res_reg;

    logic                      sweep_reg;
    logic                      sweep_next;
    logic [BW-1:0]             cnt_reg;
    logic [BW-1:0]             cnt_next;

    logic [NSL-1:0]            hit_mask;
    logic [NSL-1:0]            free_mask;
    logic                      hit;
    logic                      has_free;
    logic [63:0]               hit_value;

    logic [NSL-1:0]            nv;
    logic [NSL-1:0][31:0]      nk;
    logic [NSL-1:0][63:0]      nd;
    res_t                      res_next;
    logic                      mod;
    logic                      clr;

    logic                      out_free;
    logic                      rd_leave;
    logic                      rd_load;
    logic                      clear_go;
    logic                      wr_en;
    logic                      fwd;
    logic                      v_we;
    logic [BW-1:0]             v_waddr;
    logic [NSL-1:0]            v_wdata;

    // slot match: first matching valid slot, lowest free slot
    always_comb
    begin
        logic hit_seen;
        logic free_seen;
        hit_mask  = '0;
        free_mask = '0;
        hit_seen  = 1'b0;
        free_seen = 1'b0;
        hit_value = '0;
        for (int i = 0; i < NSL; i++)
        begin
            if (row_v_reg[i])
            begin
                if (!hit_seen && (row_k_reg[i] == 32'(rd_req_reg.key)))
                begin
                    hit_mask[i] = 1'b1;
                    hit_seen    = 1'b1;
                end
            end
            else if (!free_seen)
            begin
                free_mask[i] = 1'b1;
                free_seen    = 1'b1;
            end
        end
        for (int i = 0; i < NSL; i++)
        begin
            if (hit_mask[i])
            begin
                hit_value = hit_value | row_d_reg[i];
            end
        end
        hit      = hit_seen;
        has_free = free_seen;
    end

    // row update and response
    always_comb
    begin
        nv       = row_v_reg;
        nk       = row_k_reg;
        nd       = row_d_reg;
        res_next = '0;
        mod      = 1'b0;
        clr      = 1'b0;
        case (rd_req_reg.operation)
            OP_ADD, OP_PUT:
            begin
                if (hit)
                begin
                    res_next.found = 1'b1;
                    if (rd_req_reg.operation == OP_PUT)
                    begin
                        res_next.ok = 1'b1;
                        mod         = 1'b1;
                        for (int i = 0; i < NSL; i++)
                        begin
                            if (hit_mask[i])
                            begin
                                nd[i] = rd_req_reg.value;
                            end
                        end
                    end
                end
                else if (has_free)
                begin
                    res_next.ok = 1'b1;
                    mod         = 1'b1;
                    nv          = row_v_reg | free_mask;
                    for (int i = 0; i < NSL; i++)
                    begin
                        if (free_mask[i])
                        begin
                            nk[i] = 32'(rd_req_reg.key);
                            nd[i] = rd_req_reg.value;
                        end
                    end
                end
                else
                begin
                    res_next.bucket_full = 1'b1;
                end
            end
            OP_DEL:
            begin
                if (hit)
                begin
                    res_next.found = 1'b1;
                    res_next.ok    = 1'b1;
                    mod            = 1'b1;
                    nv             = row_v_reg & ~hit_mask;
                end
            end
            OP_GET:
            begin
                if (hit)
                begin
                    res_next.found      = 1'b1;
                    res_next.ok         = 1'b1;
                    res_next.read_value = hit_value;
                end
            end
            OP_CLEAR:
            begin
                res_next.ok = 1'b1;
                clr         = 1'b1;
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    assign out_free = !res_valid_reg || out_ready;
    assign rd_leave = rd_valid_reg && out_free;
    assign clear_go = rd_leave && clr;
    assign wr_en    = rd_leave && mod;
    assign rd_load  = in_valid && (!rd_valid_reg || rd_leave) && !sweep_reg && !clear_go;
    assign fwd      = wr_en && (rd_bucket_reg == in_bucket);

    assign v_we    = sweep_reg || wr_en;
    assign v_waddr = sweep_reg ? cnt_reg : rd_bucket_reg;
    assign v_wdata = sweep_reg ? '0 : nv;

    // sweep over all rows after reset and after clear
    always_comb
    begin
        sweep_next = sweep_reg;
        cnt_next   = cnt_reg;
        if (clear_go)
        begin
            sweep_next = 1'b1;
            cnt_next   = '0;
        end
        else if (sweep_reg)
        begin
            if (cnt_reg == LAST_ROW)
            begin
                sweep_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + BW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= 1'b1;
            cnt_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            sweep_reg <= sweep_next;
            cnt_reg   <= cnt_next;
            if (rd_load)
            begin
                rd_valid_reg <= 1'b1;
            end
            else if (rd_leave)
            begin
                rd_valid_reg <= 1'b0;
            end
            if (rd_leave)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            vmem[v_waddr] <= v_wdata;
        end
        if (wr_en)
        begin
            kmem[rd_bucket_reg] <= nk;
            dmem[rd_bucket_reg] <= nd;
        end
        if (rd_load)
        begin
            rd_req_reg    <= in_req;
            rd_bucket_reg <= in_bucket;
            if (fwd)
            begin
                row_v_reg <= nv;
                row_k_reg <= nk;
                row_d_reg <= nd;
            end
            else
            begin
                row_v_reg <= vmem[in_bucket];
                row_k_reg <= kmem[in_bucket];
                row_d_reg <= dmem[in_bucket];
            end
        end
        if (rd_leave)
        begin
            res_reg <= res_next;
        end
    end

    assign stat.take     = rd_load;
    assign stat.sweeping = sweep_reg;
    assign out_valid     = res_valid_reg;
    assign out_res       = res_reg;

endmodule

`default_nettype wire

// ===== sv/int_key_hash_table_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// pipeline: 7 hash stages, then the row read register and the response
// register; one request accepted per cycle when not stalled
// throughput: one beat per cycle when not stalled; a clear holds
// requests off while the valid bits of every row are swept to zero
// reset: rst_n low clears control state; after release the valid sweep
// runs over every row with req.ready low
// ----------------------------------------------------------------------------
// int_key_hash_table_core
// Bucketed hash table with 32-bit signed keys and 64-bit values.
// ----------------------------------------------------------------------------

module int_key_hash_table_core
    import ikht_pkg::*;
#(
    parameter int BUCKETS          = 256,
    parameter int SLOTS_PER_BUCKET = 4
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    ikht_req_if.sink    req,
    ikht_res_if.source  res
);

    localparam int BW = $clog2(BUCKETS);

    req_t          in_req;
    logic          adv;
    logic          in_take;
    logic          h_valid;
    req_t          h_req;
    logic [BW-1:0] h_bucket;
    tbl_stat_t     stat;
    logic          o_valid;
    res_t          o_res;

    assign in_req.operation = req.operation;
    assign in_req.key       = req.key;
    assign in_req.value     = req.value;

    assign adv       = !h_valid || stat.take;
    assign req.ready = adv && !stat.sweeping;
    assign in_take   = req.valid && req.ready;

    ikht_hash #(
        .BUCKETS (BUCKETS)
    ) u_hash (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_take    (in_take),
        .in_req     (in_req),
        .out_valid  (h_valid),
        .out_req    (h_req),
        .out_bucket (h_bucket)
    );

    ikht_table #(
        .BUCKETS          (BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (h_valid),
        .in_req    (h_req),
        .in_bucket (h_bucket),
        .out_ready (res.ready),
        .stat      (stat),
        .out_valid (o_valid),
        .out_res   (o_res)
    );

    assign res.valid       = o_valid;
    assign res.found       = o_res.found;
    assign res.ok          = o_res.ok;
    assign res.bucket_full = o_res.bucket_full;
    assign res.read_value  = o_res.read_value;

endmodule

`default_nettype wire
